[rtl/skjp_pkg.sv]
`default_nettype none
package skjp_pkg;

	localparam int MAX_JOINTS_DEF = 64;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ACC_W          = 68;

	localparam logic [2:0] CMD_POS     = 3'd0;
	localparam logic [2:0] CMD_QUAT    = 3'd1;
	localparam logic [2:0] CMD_SCALE   = 3'd2;
	localparam logic [2:0] CMD_IBIND   = 3'd3;
	localparam logic [2:0] CMD_COMPUTE = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_JOINT  = 2'd1;
	localparam logic [1:0] ST_BAD_PARENT = 2'd2;

	localparam logic [1:0] DST_ROT = 2'd0;
	localparam logic [1:0] DST_LOC = 2'd1;
	localparam logic [1:0] DST_WLD = 2'd2;
	localparam logic [1:0] DST_FIN = 2'd3;

	// Word slots of one joint in the parameter memory.
	localparam logic [4:0] SLOT_POS    = 5'd0;
	localparam logic [4:0] SLOT_PARENT = 5'd3;
	localparam logic [4:0] SLOT_QUAT   = 5'd4;
	localparam logic [4:0] SLOT_SCALE  = 5'd8;
	localparam logic [4:0] SLOT_IBIND  = 5'd16;
	localparam logic [3:0] FETCH_LAST  = 4'd10;

	localparam logic [1:0] Q_X = 2'd0;
	localparam logic [1:0] Q_Y = 2'd1;
	localparam logic [1:0] Q_Z = 2'd2;
	localparam logic [1:0] Q_W = 2'd3;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 68'sd2147483647;
	localparam logic signed [ACC_W-1:0] SAT_MIN = -68'sd2147483648;

	typedef struct packed {
		logic               valid;
		logic               a_ram;
		logic               b_ram;
		logic signed [31:0] a_val;
		logic signed [31:0] b_val;
		logic               first;
		logic               last;
		logic               neg;
		logic               dbl;
		logic               init_one;
		logic [1:0]         dst_kind;
		logic [3:0]         dst_idx;
	} mac_op_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         dst_kind;
		logic [3:0]         dst_idx;
		logic signed [31:0] value;
	} mac_res_t;

	typedef struct packed {
		logic [1:0] a_idx;
		logic [1:0] b_idx;
		logic       neg;
		logic       init_one;
	} rot_term_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX)
			r = 32'sh7FFFFFFF;
		else if (v < SAT_MIN)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Rotation element e is built from two doubled quaternion products.
	function automatic rot_term_t rot_term(input logic [3:0] e, input logic t);
		rot_term_t r;
		r.init_one = 1'b0;
		r.neg      = 1'b0;
		r.a_idx    = Q_X;
		r.b_idx    = Q_X;
		case (e)
			4'd0: begin
				r.init_one = 1'b1; r.neg = 1'b1;
				r.a_idx = t ? Q_Z : Q_Y; r.b_idx = t ? Q_Z : Q_Y;
			end
			4'd1: begin
				r.a_idx = t ? Q_W : Q_X; r.b_idx = t ? Q_Z : Q_Y; r.neg = t;
			end
			4'd2: begin
				r.a_idx = t ? Q_W : Q_X; r.b_idx = t ? Q_Y : Q_Z;
			end
			4'd3: begin
				r.a_idx = t ? Q_W : Q_X; r.b_idx = t ? Q_Z : Q_Y;
			end
			4'd4: begin
				r.init_one = 1'b1; r.neg = 1'b1;
				r.a_idx = t ? Q_Z : Q_X; r.b_idx = t ? Q_Z : Q_X;
			end
			4'd5: begin
				r.a_idx = t ? Q_W : Q_Y; r.b_idx = t ? Q_X : Q_Z; r.neg = t;
			end
			4'd6: begin
				r.a_idx = t ? Q_W : Q_X; r.b_idx = t ? Q_Y : Q_Z; r.neg = t;
			end
			4'd7: begin
				r.a_idx = t ? Q_W : Q_Y; r.b_idx = t ? Q_X : Q_Z;
			end
			4'd8: begin
				r.init_one = 1'b1; r.neg = 1'b1;
				r.a_idx = t ? Q_Y : Q_X; r.b_idx = t ? Q_Y : Q_X;
			end
			default: begin
				r.init_one = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/skjp_if.sv]
`default_nettype none
interface skjp_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [5:0]         joint;
	logic [1:0]         row;
	logic [5:0]         parent;
	logic signed [31:0] value_a;
	logic signed [31:0] value_b;
	logic signed [31:0] value_c;
	logic signed [31:0] value_d;
	modport source(output valid, cmd, joint, row, parent, value_a, value_b, value_c,
		value_d, input ready);
	modport sink(input valid, cmd, joint, row, parent, value_a, value_b, value_c,
		value_d, output ready);
endinterface

interface skjp_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_joint;
	logic [1:0]         out_row;
	logic signed [31:0] col0;
	logic signed [31:0] col1;
	logic signed [31:0] col2;
	logic signed [31:0] col3;
	logic               last_row;
	logic [1:0]         status;
	modport source(output valid, out_joint, out_row, col0, col1, col2, col3, last_row,
		status, input ready);
	modport sink(input valid, out_joint, out_row, col0, col1, col2, col3, last_row,
		status, output ready);
endinterface

interface skjp_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/skeletal_joint_palette_core.sv]
`default_nettype none
// Load items make four memory writes; unused commands are taken and dropped.
// A compute item runs 11 parameter reads and 1 parent check, then 18 rotation, 9 scale,
// 64 world and 64 final products through the one shared multiply-accumulate, issued
// one per cycle within a phase, with a drain after the rotation, scale and world phases
// and after each row; a finished row also waits while the output register is full.
// One item is in work at a time; input ready waits until the output register is free.
// arst_n clears the sequencer, the computed flags, the output valid and joint_count to 1.
module skeletal_joint_palette_core #(
	parameter int MAX_JOINTS = skjp_pkg::MAX_JOINTS_DEF,
	parameter int FRAC_BITS  = skjp_pkg::FRAC_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	skjp_in_if.sink    in_ch,
	skjp_out_if.source out_ch,
	skjp_cfg_if.sink   cfg
);
	import skjp_pkg::*;

	localparam int JW = $clog2(MAX_JOINTS);
	localparam logic [8:0] MAXJ_V = 9'(MAX_JOINTS);
	localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_FETCH = 4'd2;
	localparam logic [3:0] S_PCHK  = 4'd3;
	localparam logic [3:0] S_ROT   = 4'd4;
	localparam logic [3:0] S_LOC   = 4'd5;
	localparam logic [3:0] S_WORLD = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_ROWW  = 4'd8;
	localparam logic [3:0] S_DRAIN = 4'd9;

	logic [3:0]         state_q, nxt_q;
	logic [3:0]         cnt_q, e_q, fidx_q;
	logic               t_q, fvalid_q;
	logic [1:0]         k_q, c_q, r_q;
	logic [JW-1:0]      j_q, par_q;
	logic [2:0]         cmd_q;
	logic [1:0]         row_q;
	logic [5:0]         pin_q;
	logic signed [31:0] v_q [4];
	logic signed [31:0] op_q [11];
	logic signed [31:0] rot_q [9];
	logic signed [31:0] loc_q [9];
	logic signed [31:0] fin_q [4];
	logic [MAX_JOINTS-1:0] computed_q;
	logic [6:0]         jc_q;

	logic               out_valid_q, last_q;
	logic [5:0]         oj_q;
	logic [1:0]         orow_q, ost_q;
	logic signed [31:0] ocol_q [4];

	logic               in_acc, j_ok, par_ok;
	logic [5:0]         p6;
	rot_term_t          rt;
	mac_op_t            mop;
	mac_res_t           mres;
	logic               busy;
	logic signed [31:0] lval;
	logic [4:0]         ld_slot;

	logic                d_we;
	logic [JW+4:0]       d_waddr, d_raddr;
	logic [31:0]         d_wdata, d_rdata;
	logic [JW+3:0]       w_raddr;
	logic [31:0]         w_rdata;

	skjp_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS * 32)) u_param_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	skjp_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS * 16)) u_world_ram (
		.clk(clk), .we(mres.valid && (mres.dst_kind == DST_WLD)),
		.waddr({j_q, mres.dst_idx}), .wdata(mres.value),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	skjp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk(clk), .arst_n(arst_n), .op(mop), .a_mem(w_rdata), .b_mem(d_rdata),
		.res(mres), .busy(busy)
	);

	assign in_ch.ready  = (state_q == S_IDLE) && !out_valid_q;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign cfg.ready    = 1'b1;
	assign j_ok         = (7'(in_ch.joint) < jc_q) && (9'(in_ch.joint) < MAXJ_V);
	assign p6           = op_q[3][5:0];
	assign par_ok       = (9'(p6) < 9'(j_q)) && computed_q[JW'(p6)];
	assign rt           = rot_term(e_q, t_q);

	always_comb begin
		case (cmd_q)
			CMD_POS:   ld_slot = SLOT_POS;
			CMD_QUAT:  ld_slot = SLOT_QUAT;
			CMD_SCALE: ld_slot = SLOT_SCALE;
			default:   ld_slot = SLOT_IBIND | {1'b0, row_q, 2'b00};
		endcase
	end

	assign d_we    = (state_q == S_LOAD);
	assign d_waddr = {j_q, ld_slot + {3'b000, cnt_q[1:0]}};
	assign d_wdata = ((cmd_q == CMD_POS) && (cnt_q[1:0] == 2'd3)) ? {26'd0, pin_q}
		: v_q[cnt_q[1:0]];
	assign d_raddr = (state_q == S_FIN) ? {j_q, 1'b1, k_q, c_q} : {j_q, 1'(0), cnt_q};
	assign w_raddr = (state_q == S_FIN) ? {j_q, r_q, k_q} : {par_q, r_q, k_q};

	// Element (k, c) of the local matrix; the last row and column come from constants
	// and the position.
	always_comb begin
		if (k_q == 2'd3)
			lval = (c_q == 2'd3) ? ONE32 : 32'sd0;
		else if (c_q == 2'd3)
			lval = op_q[{2'b00, k_q}];
		else
			lval = loc_q[4'({2'b00, k_q} * 4'd3 + {2'b00, c_q})];
	end

	always_comb begin
		mop = '0;
		case (state_q)
			S_ROT: begin
				mop.valid    = 1'b1;
				mop.a_val    = op_q[4'd4 + {2'b00, rt.a_idx}];
				mop.b_val    = op_q[4'd4 + {2'b00, rt.b_idx}];
				mop.first    = !t_q;
				mop.last     = t_q;
				mop.neg      = rt.neg;
				mop.dbl      = 1'b1;
				mop.init_one = rt.init_one;
				mop.dst_kind = DST_ROT;
				mop.dst_idx  = e_q;
			end
			S_LOC: begin
				mop.valid    = 1'b1;
				mop.a_val    = rot_q[e_q];
				mop.b_val    = op_q[4'd8 + {2'b00, c_q}];
				mop.first    = 1'b1;
				mop.last     = 1'b1;
				mop.dst_kind = DST_LOC;
				mop.dst_idx  = e_q;
			end
			S_WORLD: begin
				// Joint 0 multiplies the local matrix by identity.
				mop.valid    = 1'b1;
				mop.a_ram    = (j_q != '0);
				mop.a_val    = (r_q == k_q) ? ONE32 : 32'sd0;
				mop.b_val    = lval;
				mop.first    = (k_q == 2'd0);
				mop.last     = (k_q == 2'd3);
				mop.dst_kind = DST_WLD;
				mop.dst_idx  = {r_q, c_q};
			end
			S_FIN: begin
				mop.valid    = 1'b1;
				mop.a_ram    = 1'b1;
				mop.b_ram    = 1'b1;
				mop.first    = (k_q == 2'd0);
				mop.last     = (k_q == 2'd3);
				mop.dst_kind = DST_FIN;
				mop.dst_idx  = {2'b00, c_q};
			end
			default: begin
				mop = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= in_ch.cmd;
			row_q  <= in_ch.row;
			pin_q  <= in_ch.parent;
			j_q    <= JW'(in_ch.joint);
			v_q[0] <= in_ch.value_a;
			v_q[1] <= in_ch.value_b;
			v_q[2] <= in_ch.value_c;
			v_q[3] <= in_ch.value_d;
		end
		if (fvalid_q)
			op_q[fidx_q] <= d_rdata;
		if (state_q == S_PCHK)
			par_q <= JW'(p6);
		if (mres.valid) begin
			case (mres.dst_kind)
				DST_ROT: rot_q[mres.dst_idx] <= mres.value;
				DST_LOC: loc_q[mres.dst_idx] <= mres.value;
				DST_FIN: fin_q[mres.dst_idx[1:0]] <= mres.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nxt_q       <= S_IDLE;
			cnt_q       <= '0;
			e_q         <= '0;
			t_q         <= 1'b0;
			k_q         <= '0;
			c_q         <= '0;
			r_q         <= '0;
			fvalid_q    <= 1'b0;
			fidx_q      <= '0;
			computed_q  <= '0;
			jc_q        <= 7'd1;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			oj_q        <= '0;
			orow_q      <= '0;
			ost_q       <= ST_OK;
			for (int i = 0; i < 4; i++)
				ocol_q[i] <= '0;
		end else begin
			if (cfg.valid && cfg.ready)
				jc_q <= cfg.data;
			if (out_ch.valid && out_ch.ready)
				out_valid_q <= 1'b0;
			fvalid_q <= (state_q == S_FETCH);
			fidx_q   <= cnt_q;

			case (state_q)
				S_IDLE: begin
					if (in_acc && (in_ch.cmd <= CMD_COMPUTE)) begin
						cnt_q <= '0;
						if (!j_ok) begin
							out_valid_q <= 1'b1;
							oj_q        <= in_ch.joint;
							orow_q      <= 2'd0;
							last_q      <= 1'b1;
							ost_q       <= ST_BAD_JOINT;
							for (int i = 0; i < 4; i++)
								ocol_q[i] <= '0;
						end else if (in_ch.cmd == CMD_COMPUTE) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3)
						state_q <= S_IDLE;
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == FETCH_LAST)
						state_q <= S_PCHK;
				end
				S_PCHK: begin
					e_q <= '0;
					t_q <= 1'b0;
					if ((j_q == '0) || par_ok) begin
						computed_q[j_q] <= 1'b1;
						state_q         <= S_ROT;
					end else begin
						out_valid_q <= 1'b1;
						oj_q        <= 6'(j_q);
						orow_q      <= 2'd0;
						last_q      <= 1'b1;
						ost_q       <= ST_BAD_PARENT;
						for (int i = 0; i < 4; i++)
							ocol_q[i] <= '0;
						state_q <= S_IDLE;
					end
				end
				S_ROT: begin
					t_q <= !t_q;
					if (t_q) begin
						if (e_q == 4'd8) begin
							e_q     <= '0;
							c_q     <= '0;
							nxt_q   <= S_LOC;
							state_q <= S_DRAIN;
						end else begin
							e_q <= e_q + 4'd1;
						end
					end
				end
				S_LOC: begin
					if (e_q == 4'd8) begin
						k_q     <= '0;
						c_q     <= '0;
						r_q     <= '0;
						nxt_q   <= S_WORLD;
						state_q <= S_DRAIN;
					end else begin
						e_q <= e_q + 4'd1;
						c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
					end
				end
				S_WORLD: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						c_q <= c_q + 2'd1;
						if (c_q == 2'd3) begin
							r_q <= r_q + 2'd1;
							if (r_q == 2'd3) begin
								nxt_q   <= S_FIN;
								state_q <= S_DRAIN;
							end
						end
					end
				end
				S_FIN: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						c_q <= c_q + 2'd1;
						if (c_q == 2'd3)
							state_q <= S_ROWW;
					end
				end
				S_ROWW: begin
					if (!busy && !out_valid_q) begin
						out_valid_q <= 1'b1;
						oj_q        <= 6'(j_q);
						orow_q      <= r_q;
						last_q      <= (r_q == 2'd3);
						ost_q       <= ST_OK;
						for (int i = 0; i < 4; i++)
							ocol_q[i] <= fin_q[i];
						r_q     <= r_q + 2'd1;
						state_q <= (r_q == 2'd3) ? S_IDLE : S_FIN;
					end
				end
				S_DRAIN: begin
					if (!busy)
						state_q <= nxt_q;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_joint = oj_q;
	assign out_ch.out_row   = orow_q;
	assign out_ch.col0      = ocol_q[0];
	assign out_ch.col1      = ocol_q[1];
	assign out_ch.col2      = ocol_q[2];
	assign out_ch.col3      = ocol_q[3];
	assign out_ch.last_row  = last_q;
	assign out_ch.status    = ost_q;
endmodule
`default_nettype wire

[rtl/skjp_ram.sv]
`default_nettype none
module skjp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/skjp_mac.sv]
`default_nettype none
module skjp_mac #(
	parameter int FRAC_BITS = skjp_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire skjp_pkg::mac_op_t  op,
	input  wire logic signed [31:0] a_mem,
	input  wire logic signed [31:0] b_mem,
	output skjp_pkg::mac_res_t      res,
	output logic                    busy
);
	import skjp_pkg::*;

	localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1) << FRAC_BITS;

	mac_op_t                  op_s1;
	mac_op_t                  ctl_s2;
	logic signed [63:0]       prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0]       a_op;
	logic signed [31:0]       b_op;
	logic signed [63:0]       term;
	logic signed [ACC_W-1:0]  term_x;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  sum;

	assign a_op = op_s1.a_ram ? a_mem : op_s1.a_val;
	assign b_op = op_s1.b_ram ? b_mem : op_s1.b_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= '0;
			ctl_s2 <= '0;
		end else begin
			op_s1  <= op;
			ctl_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_op * b_op;
		if (ctl_s2.valid)
			acc_q <= sum;
	end

	// The arithmetic shift floors the product, matching truncation toward minus infinity.
	always_comb begin
		term   = prod_s2 >>> FRAC_BITS;
		term_x = ctl_s2.dbl ? (ACC_W'(term) <<< 1) : ACC_W'(term);
		if (ctl_s2.first)
			base = ctl_s2.init_one ? ONE : '0;
		else
			base = acc_q;
		sum = ctl_s2.neg ? (base - term_x) : (base + term_x);
	end

	assign res.valid    = ctl_s2.valid && ctl_s2.last;
	assign res.dst_kind = ctl_s2.dst_kind;
	assign res.dst_idx  = ctl_s2.dst_idx;
	assign res.value    = sat32(sum);
	assign busy         = op_s1.valid || ctl_s2.valid;
endmodule
`default_nettype wire

[rtl/skjp_checker.sv]
`default_nettype none
module skjp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [2:0]  in_cmd,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_row,
	input wire logic        out_last,
	input wire logic [1:0]  out_status,
	input wire logic [31:0] out_col0
);
	import skjp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_status))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != ST_OK) |-> out_last && (out_row == 2'd0)
		&& (out_col0 == 32'd0))
		else $error("malformed error result");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_cmd <= CMD_COMPUTE) |=> !in_ready)
		else $error("ready right after a command transfer");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");
endmodule

bind skeletal_joint_palette_core skjp_checker u_skjp_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_row(out_ch.out_row),
	.out_last(out_ch.last_row), .out_status(out_ch.status), .out_col0(out_ch.col0)
);
`default_nettype wire

[test/tb_skeletal_joint_palette_core.sv]
`timescale 1ns / 1ps
module tb_skeletal_joint_palette_core;
	import skjp_pkg::*;

	localparam int  FRAC      = 16;
	localparam longint ONE    = 64'sd1 << FRAC;
	localparam int  IDLE_LIMIT = 5000;
	localparam int  SETTLE    = 300;

	typedef longint mat_t[16];

	typedef struct {
		logic [5:0]  joint;
		logic [1:0]  row;
		logic [31:0] col[4];
		logic        last;
		logic [1:0]  status;
	} palette_row_t;

	logic clk;
	logic arst_n;

	skjp_in_if  in_ch();
	skjp_out_if out_ch();
	skjp_cfg_if cfg();

	skeletal_joint_palette_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// Shadow copy of the joint tables.
	longint pos_tab[64][3];
	longint quat_tab[64][4];
	longint scale_tab[64][3];
	logic [5:0] parent_tab[64];
	mat_t ibind_tab[64];
	mat_t world_tab[64];
	bit world_done[64];
	// Bit 0 position, 1 quaternion, 2 scale, 3..6 inverse bind rows.
	logic [6:0] loaded[64];
	int unsigned joints_in_use;

	palette_row_t expected_rows[$];
	int errors;
	int items_sent;
	int rx_hold;
	bit rx_no_idle;
	bit tx_no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint fx_mul(longint a, longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic longint sat_32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic mat_t mat_mul(mat_t a, mat_t b);
		mat_t d;
		longint acc;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += fx_mul(a[r*4+k], b[k*4+c]);
				d[r*4+c] = sat_32(acc);
			end
		return d;
	endfunction

	function automatic mat_t joint_local(int j);
		mat_t m;
		longint rot[9];
		longint x, y, z, w, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		x = quat_tab[j][0]; y = quat_tab[j][1]; z = quat_tab[j][2]; w = quat_tab[j][3];
		xx = fx_mul(x, x); yy = fx_mul(y, y); zz = fx_mul(z, z);
		xy = fx_mul(x, y); xz = fx_mul(x, z); yz = fx_mul(y, z);
		wx = fx_mul(w, x); wy = fx_mul(w, y); wz = fx_mul(w, z);
		rot[0] = sat_32(ONE - 2 * (yy + zz));
		rot[1] = sat_32(2 * (xy - wz));
		rot[2] = sat_32(2 * (xz + wy));
		rot[3] = sat_32(2 * (xy + wz));
		rot[4] = sat_32(ONE - 2 * (xx + zz));
		rot[5] = sat_32(2 * (yz - wx));
		rot[6] = sat_32(2 * (xz - wy));
		rot[7] = sat_32(2 * (yz + wx));
		rot[8] = sat_32(ONE - 2 * (xx + yy));
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++)
				m[r*4+c] = sat_32(fx_mul(rot[r*3+c], scale_tab[j][c]));
			m[r*4+3] = pos_tab[j][r];
		end
		m[12] = 0; m[13] = 0; m[14] = 0; m[15] = ONE;
		return m;
	endfunction

	task automatic push_error_row(logic [5:0] j, logic [1:0] st);
		palette_row_t e;
		e.joint = j; e.row = 2'd0; e.last = 1'b1; e.status = st;
		for (int c = 0; c < 4; c++)
			e.col[c] = '0;
		expected_rows.push_back(e);
	endtask

	// Applies one accepted item to the shadow tables and queues its rows.
	task automatic palette_predict(logic [2:0] cmd, logic [5:0] j, logic [1:0] row,
		logic [5:0] par, logic signed [31:0] v[4]);
		int unsigned lim;
		logic [5:0] p;
		mat_t fin;
		palette_row_t e;
		lim = (joints_in_use < 64) ? joints_in_use : 64;
		if (cmd > CMD_COMPUTE)
			return;
		if (j >= lim) begin
			push_error_row(j, ST_BAD_JOINT);
			return;
		end
		case (cmd)
			CMD_POS: begin
				for (int k = 0; k < 3; k++)
					pos_tab[j][k] = v[k];
				parent_tab[j] = par;
				loaded[j][0] = 1'b1;
			end
			CMD_QUAT: begin
				for (int k = 0; k < 4; k++)
					quat_tab[j][k] = v[k];
				loaded[j][1] = 1'b1;
			end
			CMD_SCALE: begin
				for (int k = 0; k < 3; k++)
					scale_tab[j][k] = v[k];
				loaded[j][2] = 1'b1;
			end
			CMD_IBIND: begin
				for (int k = 0; k < 4; k++)
					ibind_tab[j][row*4+k] = v[k];
				loaded[j][3+row] = 1'b1;
			end
			default: begin
				if (j != 0) begin
					p = parent_tab[j];
					if (p >= j || !world_done[p]) begin
						push_error_row(j, ST_BAD_PARENT);
						return;
					end
					world_tab[j] = mat_mul(world_tab[p], joint_local(j));
				end else begin
					world_tab[0] = joint_local(0);
				end
				world_done[j] = 1'b1;
				fin = mat_mul(world_tab[j], ibind_tab[j]);
				for (int r = 0; r < 4; r++) begin
					e.joint = j; e.row = r[1:0]; e.last = (r == 3); e.status = ST_OK;
					for (int c = 0; c < 4; c++)
						e.col[c] = fin[r*4+c][31:0];
					expected_rows.push_back(e);
				end
			end
		endcase
	endtask

	task automatic send_item(logic [2:0] cmd, logic [5:0] j, logic [1:0] row,
		logic [5:0] par, logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c, logic signed [31:0] d);
		int gap;
		logic signed [31:0] v[4];
		gap = tx_no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.cmd     <= cmd;
		in_ch.joint   <= j;
		in_ch.row     <= row;
		in_ch.parent  <= par;
		in_ch.value_a <= a;
		in_ch.value_b <= b;
		in_ch.value_c <= c;
		in_ch.value_d <= d;
		do @(posedge clk); while (!in_ch.ready);
		v[0] = a; v[1] = b; v[2] = c; v[3] = d;
		palette_predict(cmd, j, row, par, v);
		items_sent++;
	endtask

	// Drops valid in the step of the last transfer, then lets the block drain.
	task automatic drain_and_settle();
		in_ch.valid <= 1'b0;
		wait (expected_rows.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_joint_count(logic [6:0] n);
		drain_and_settle();
		cfg.valid <= 1'b1;
		cfg.data  <= n;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		joints_in_use = n;
	endtask

	function automatic logic signed [31:0] pick_val();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3: return $urandom;
			default: return $signed($urandom_range(0, 262143)) - 32'sd131072;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_quat();
		if ($urandom_range(0, 15) == 0)
			return pick_val();
		return $signed($urandom_range(0, 131072)) - 32'sd65536;
	endfunction

	// Full load of one joint: position and parent, rotation, scale, inverse bind.
	task automatic load_joint(logic [5:0] j, logic [5:0] par);
		send_item(CMD_POS, j, $urandom, par, pick_val(), pick_val(), pick_val(), $urandom);
		send_item(CMD_QUAT, j, $urandom, $urandom, pick_quat(), pick_quat(), pick_quat(),
			pick_quat());
		send_item(CMD_SCALE, j, $urandom, $urandom, pick_quat(), pick_quat(), pick_quat(),
			$urandom);
		for (int r = 0; r < 4; r++)
			send_item(CMD_IBIND, j, r[1:0], $urandom, pick_val(), pick_val(), pick_val(),
				pick_val());
	endtask

	task automatic compute_joint(logic [5:0] j);
		send_item(CMD_COMPUTE, j, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom);
	endtask

	function automatic logic [5:0] pick_parent(int j);
		int p;
		if (j == 0 || $urandom_range(0, 7) == 0)
			return $urandom;
		for (int t = 0; t < 8; t++) begin
			p = $urandom_range(0, j - 1);
			if (world_done[p])
				return p[5:0];
		end
		return $urandom_range(0, j - 1);
	endfunction

	task automatic test_directed();
		logic signed [31:0] id_row[4];
		// Only joint 0 is in use after reset.
		compute_joint(6'd1);
		send_item(3'd5, 6'd0, 2'd3, 6'd63, 32'sh7FFFFFFF, 0, 0, 0);
		send_item(3'd6, 6'd63, 2'd0, 6'd0, 32'sh80000000, 0, 0, 0);
		send_item(3'd7, 6'd0, 2'd1, 6'd5, -1, -1, -1, -1);
		send_item(CMD_POS, 6'd0, 2'd0, 6'd5, 32'sd65536, -32'sd131072, 32'sd7, 0);
		send_item(CMD_QUAT, 6'd0, 2'd0, 6'd0, 0, 0, 0, 32'sd65536);
		send_item(CMD_SCALE, 6'd0, 2'd0, 6'd0, 32'sd65536, 32'sd65536, 32'sd65536, 0);
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++)
				id_row[c] = (r == c) ? 32'sd65536 : 32'sd0;
			send_item(CMD_IBIND, 6'd0, r[1:0], 6'd0, id_row[0], id_row[1], id_row[2],
				id_row[3]);
		end
		compute_joint(6'd0);
		write_joint_count(7'd64);
		// Parent not yet computed, then parent not earlier.
		load_joint(6'd63, 6'd62);
		compute_joint(6'd63);
		load_joint(6'd1, 6'd1);
		compute_joint(6'd1);
		send_item(CMD_POS, 6'd1, 2'd0, 6'd0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0);
		compute_joint(6'd1);
		// Extreme values saturate the products.
		send_item(CMD_POS, 6'd2, 2'd0, 6'd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0);
		send_item(CMD_QUAT, 6'd2, 2'd0, 6'd0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF);
		send_item(CMD_SCALE, 6'd2, 2'd0, 6'd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
			0);
		for (int r = 0; r < 4; r++)
			send_item(CMD_IBIND, 6'd2, r[1:0], 6'd0, 32'sh7FFFFFFF, 32'sh80000000,
				32'sh7FFFFFFF, 32'sh80000000);
		compute_joint(6'd2);
		// Reloading joint 1 keeps its old world matrix for joint 2.
		send_item(CMD_POS, 6'd1, 2'd0, 6'd0, 0, 0, 0, 0);
		compute_joint(6'd2);
	endtask

	task automatic test_random(int n_items);
		int target;
		int lim;
		int j;
		target = items_sent + n_items;
		lim = (joints_in_use < 64) ? joints_in_use : 64;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				0: send_item($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				1: begin
					if (lim < 64)
						j = $urandom_range(lim, 63);
					else
						j = $urandom_range(0, 63);
					if (j >= lim || loaded[j] == 7'h7F)
						send_item($urandom_range(0, 4), j, $urandom, $urandom, $urandom,
							$urandom, $urandom, $urandom);
				end
				2: begin
					j = $urandom_range(0, lim - 1);
					if (loaded[j] == 7'h7F)
						compute_joint(j);
				end
				default: begin
					j = $urandom_range(0, lim - 1);
					load_joint(j, pick_parent(j));
					compute_joint(j);
				end
			endcase
		end
	endtask

	task automatic test_joint_count_sweep();
		write_joint_count(7'd1);
		test_random(60);
		write_joint_count($urandom_range(2, 63));
		test_random(100);
		write_joint_count(7'd64);
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		test_random(60);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		test_random(150);
	endtask

	task automatic test_output_backpressure();
		drain_and_settle();
		rx_hold = 600;
		tx_no_idle = 1'b1;
		for (int k = 0; k < 4; k++) begin
			load_joint(k, pick_parent(k));
			compute_joint(k);
		end
		tx_no_idle = 1'b0;
	endtask

	// Result side: random stalls, long hold-off on request, and the compare.
	initial begin
		int stall;
		palette_row_t e;
		logic [31:0] got[4];
		stall = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got[0] = out_ch.col0; got[1] = out_ch.col1;
				got[2] = out_ch.col2; got[3] = out_ch.col3;
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected transfer joint %0d row %0d", $time,
						out_ch.out_joint, out_ch.out_row);
					errors++;
				end else begin
					e = expected_rows.pop_front();
					if (out_ch.out_joint !== e.joint || out_ch.out_row !== e.row ||
						out_ch.last_row !== e.last || out_ch.status !== e.status) begin
						$display("%0t: joint/row/last/status expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							$time, e.joint, e.row, e.last, e.status, out_ch.out_joint,
							out_ch.out_row, out_ch.last_row, out_ch.status);
						errors++;
					end
					for (int c = 0; c < 4; c++)
						if (got[c] !== e.col[c]) begin
							$display("%0t: joint %0d row %0d col%0d expected %h got %h",
								$time, e.joint, e.row, c, e.col[c], got[c]);
							errors++;
						end
				end
				stall = rx_no_idle ? 0 : $urandom_range(0, 3);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("tb_skeletal_joint_palette_core: errors");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		rx_hold = 0;
		rx_no_idle = 1'b0;
		tx_no_idle = 1'b0;
		joints_in_use = 1;
		for (int j = 0; j < 64; j++) begin
			loaded[j] = '0;
			world_done[j] = 1'b0;
		end
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= '0;
		in_ch.joint <= '0;
		in_ch.row <= '0;
		in_ch.parent <= '0;
		in_ch.value_a <= '0;
		in_ch.value_b <= '0;
		in_ch.value_c <= '0;
		in_ch.value_d <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_joint_count_sweep();
		test_output_backpressure();
		drain_and_settle();
		if (errors == 0)
			$display("tb_skeletal_joint_palette_core: clean");
		else
			$display("tb_skeletal_joint_palette_core: errors");
		$finish;
	end

endmodule

[sim.f]
rtl/skjp_pkg.sv
rtl/skjp_if.sv
rtl/skjp_ram.sv
rtl/skjp_mac.sv
rtl/skeletal_joint_palette_core.sv
rtl/skjp_checker.sv
test/tb_skeletal_joint_palette_core.sv
